FILE: src/rslt_pkg.sv
// rslt_pkg: shared types and constants for the remote sensor liveness table
// holds the input and result words, the slot record, controller codes and register indexes
// no dependencies
`timescale 1ns / 1ps

package rslt_pkg;

    typedef struct packed {
        logic        mode;
        logic [47:0] sender_address;
        logic [7:0]  sensor_id;
        logic [2:0]  sensor_class;
        logic [31:0] sequence_number;
        logic        sensor_ok;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  slot_index;
        logic        came_back;
        logic [31:0] received_count;
        logic [31:0] lost_count;
        logic [15:0] timeout_mask;
    } result_t;

    typedef struct packed {
        logic [47:0] address;
        logic [7:0]  sensor_number;
        logic [2:0]  sensor_class;
        logic [31:0] last_arrival;
        logic [31:0] last_sequence;
        logic [31:0] received;
        logic [31:0] lost;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_LOAD,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_issue;
        logic pick_read;
        logic calc;
        logic update;
        logic respond_plain;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic found;
    } ctrl_status_t;

    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic [2:0] CLASS_FAST    = 3'd0;
    localparam logic [2:0] CLASS_UTILITY = 3'd1;
    localparam logic [2:0] CLASS_TEMP    = 3'd2;
    localparam logic [2:0] CLASS_BATTERY = 3'd3;

    localparam logic [2:0] REG_TIMEOUT_FAST    = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_UTILITY = 3'd1;
    localparam logic [2:0] REG_TIMEOUT_TEMP    = 3'd2;
    localparam logic [2:0] REG_TIMEOUT_BATTERY = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_OTHER   = 3'd4;

    localparam logic [23:0] TIMEOUT_FAST_RST    = 24'd1000;
    localparam logic [23:0] TIMEOUT_UTILITY_RST = 24'd8000;
    localparam logic [23:0] TIMEOUT_TEMP_RST    = 24'd30000;
    localparam logic [23:0] TIMEOUT_BATTERY_RST = 24'd15000;
    localparam logic [23:0] TIMEOUT_OTHER_RST   = 24'd10000;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

FILE: src/rslt_ram.sv
// rslt_ram: generic single write, single read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module rslt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/rslt_ctrl.sv
// rslt_ctrl: sequencer for the slot scan, slot pick, record update and response
// depends on rslt_pkg for the state type and the command and status structs
`timescale 1ns / 1ps

module rslt_ctrl #(
    parameter int SLOTS = 16,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  rslt_pkg::ctrl_status_t  status,
    output rslt_pkg::ctrl_cmd_t     cmd,
    output logic [IDX_W-1:0]        scan_addr
);

    rslt_pkg::state_t state_reg;
    rslt_pkg::state_t state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rslt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            rslt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = rslt_pkg::ST_SCAN;
                end
            end
            rslt_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (cnt_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = rslt_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rslt_pkg::ST_DRAIN:
            begin
                state_next = rslt_pkg::ST_PICK;
            end
            rslt_pkg::ST_PICK:
            begin
                if (status.is_tick || !status.found)
                begin
                    cmd.respond_plain = 1'b1;
                    state_next        = rslt_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.pick_read = 1'b1;
                    state_next    = rslt_pkg::ST_LOAD;
                end
            end
            rslt_pkg::ST_LOAD:
            begin
                cmd.calc   = 1'b1;
                state_next = rslt_pkg::ST_UPDATE;
            end
            rslt_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = rslt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rslt_pkg::ST_IDLE;
            end
        endcase
    end

    assign scan_addr = cnt_reg;

endmodule

FILE: src/rslt_dpath.sv
// rslt_dpath: slot record RAM, slot flags, timeout registers, match and age logic, counters
// depends on rslt_pkg and rslt_ram
`timescale 1ns / 1ps

module rslt_dpath #(
    parameter int SLOTS = 16,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rslt_pkg::ctrl_cmd_t     cmd,
    output rslt_pkg::ctrl_status_t  status,
    input  logic [IDX_W-1:0]        scan_addr,
    input  logic                    cfg_write,
    input  logic [2:0]              cfg_index,
    input  logic [23:0]             cfg_data,
    input  rslt_pkg::item_t         item,
    output logic                    done,
    output rslt_pkg::result_t       result
);

    rslt_pkg::item_t   item_reg;
    rslt_pkg::result_t result_reg;
    rslt_pkg::rec_t    rd_rec;
    rslt_pkg::rec_t    wr_rec;
    logic [rslt_pkg::REC_W-1:0] rd_data;

    logic [23:0] tmo_fast_reg;
    logic [23:0] tmo_utility_reg;
    logic [23:0] tmo_temp_reg;
    logic [23:0] tmo_battery_reg;
    logic [23:0] tmo_other_reg;
    logic [23:0] tmo_sel;

    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] healthy_reg;
    logic [SLOTS-1:0] timed_out_reg;

    logic             eval_vld_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] sel_reg;
    logic [IDX_W-1:0] raddr;
    logic [15:0]      mask_reg;
    logic             done_reg;

    logic        gap_flag_reg;
    logic [31:0] gap_reg;
    logic [31:0] recv_old_reg;
    logic [31:0] lost_old_reg;
    logic        was_out_reg;

    logic        is_tick;
    logic [32:0] age;
    logic        expire;
    logic        key_hit;
    logic        is_free;
    logic        sel_used;
    logic [31:0] seq_old;
    logic [31:0] recv_old;
    logic [31:0] lost_old;
    logic [32:0] lost_sum;
    logic [31:0] lost_new;
    logic [31:0] recv_new;

    assign is_tick = (item_reg.mode == rslt_pkg::MODE_TICK);
    assign sel     = hit_found_reg ? hit_idx_reg : free_idx_reg;
    assign raddr   = cmd.scan_issue ? scan_addr : sel;
    assign rd_rec  = rslt_pkg::rec_t'(rd_data);

    rslt_ram #(
        .WIDTH (rslt_pkg::REC_W),
        .DEPTH (SLOTS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (sel_reg),
        .wdata (wr_rec),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // class timeout
    always_comb
    begin
        case (rd_rec.sensor_class)
            rslt_pkg::CLASS_FAST:    tmo_sel = tmo_fast_reg;
            rslt_pkg::CLASS_UTILITY: tmo_sel = tmo_utility_reg;
            rslt_pkg::CLASS_TEMP:    tmo_sel = tmo_temp_reg;
            rslt_pkg::CLASS_BATTERY: tmo_sel = tmo_battery_reg;
            default:                 tmo_sel = tmo_other_reg;
        endcase
    end

    // scan evaluation
    always_comb
    begin
        age     = {1'b0, item_reg.now_ms} - {1'b0, rd_rec.last_arrival};
        expire  = eval_vld_reg && is_tick && used_reg[eval_idx_reg]
                  && !timed_out_reg[eval_idx_reg] && healthy_reg[eval_idx_reg]
                  && (rd_rec.last_arrival != 32'd0) && !age[32]
                  && (age[31:0] > {8'd0, tmo_sel});
        key_hit = eval_vld_reg && !is_tick && used_reg[eval_idx_reg]
                  && (rd_rec.address == item_reg.sender_address)
                  && (rd_rec.sensor_number == item_reg.sensor_id);
        is_free = eval_vld_reg && !is_tick && !used_reg[eval_idx_reg];
    end

    // record update
    always_comb
    begin
        sel_used = used_reg[sel_reg];
        seq_old  = sel_used ? rd_rec.last_sequence : 32'd0;
        recv_old = sel_used ? rd_rec.received : 32'd0;
        lost_old = sel_used ? rd_rec.lost : 32'd0;
        lost_sum = {1'b0, lost_old_reg} + {1'b0, gap_reg};
        if (!gap_flag_reg)
        begin
            lost_new = lost_old_reg;
        end
        else if (lost_sum[32])
        begin
            lost_new = rslt_pkg::COUNT_MAX;
        end
        else
        begin
            lost_new = lost_sum[31:0];
        end
        recv_new = (recv_old_reg == rslt_pkg::COUNT_MAX) ? recv_old_reg
                                                         : recv_old_reg + 32'd1;
        wr_rec.address       = item_reg.sender_address;
        wr_rec.sensor_number = item_reg.sensor_id;
        wr_rec.sensor_class  = item_reg.sensor_class;
        wr_rec.last_arrival  = item_reg.now_ms;
        wr_rec.last_sequence = item_reg.sequence_number;
        wr_rec.received      = recv_new;
        wr_rec.lost          = lost_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_fast_reg    <= rslt_pkg::TIMEOUT_FAST_RST;
            tmo_utility_reg <= rslt_pkg::TIMEOUT_UTILITY_RST;
            tmo_temp_reg    <= rslt_pkg::TIMEOUT_TEMP_RST;
            tmo_battery_reg <= rslt_pkg::TIMEOUT_BATTERY_RST;
            tmo_other_reg   <= rslt_pkg::TIMEOUT_OTHER_RST;
            used_reg        <= '0;
            healthy_reg     <= '0;
            timed_out_reg   <= '0;
            eval_vld_reg    <= 1'b0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    rslt_pkg::REG_TIMEOUT_FAST:    tmo_fast_reg    <= cfg_data;
                    rslt_pkg::REG_TIMEOUT_UTILITY: tmo_utility_reg <= cfg_data;
                    rslt_pkg::REG_TIMEOUT_TEMP:    tmo_temp_reg    <= cfg_data;
                    rslt_pkg::REG_TIMEOUT_BATTERY: tmo_battery_reg <= cfg_data;
                    rslt_pkg::REG_TIMEOUT_OTHER:   tmo_other_reg   <= cfg_data;
                    default:                       ;
                endcase
            end
            eval_vld_reg <= cmd.scan_issue;
            done_reg     <= cmd.respond_plain || cmd.update;
            if (cmd.load)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (key_hit && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
            end
            if (is_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (expire)
            begin
                healthy_reg[eval_idx_reg]   <= 1'b0;
                timed_out_reg[eval_idx_reg] <= 1'b1;
            end
            if (cmd.update)
            begin
                used_reg[sel_reg]    <= 1'b1;
                healthy_reg[sel_reg] <= item_reg.sensor_ok;
                if (item_reg.sensor_ok)
                begin
                    timed_out_reg[sel_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            mask_reg <= '0;
        end
        eval_idx_reg <= scan_addr;
        if (key_hit && !hit_found_reg)
        begin
            hit_idx_reg <= eval_idx_reg;
        end
        if (is_free && !free_found_reg)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        if (expire && (32'(eval_idx_reg) < 32'd16))
        begin
            mask_reg[4'(eval_idx_reg)] <= 1'b1;
        end
        if (cmd.pick_read)
        begin
            sel_reg <= sel;
        end
        if (cmd.calc)
        begin
            gap_flag_reg <= (recv_old != 32'd0)
                            && ({1'b0, item_reg.sequence_number} > ({1'b0, seq_old} + 33'd1));
            gap_reg      <= item_reg.sequence_number - seq_old - 32'd1;
            recv_old_reg <= recv_old;
            lost_old_reg <= lost_old;
            was_out_reg  <= timed_out_reg[sel_reg];
        end
        if (cmd.respond_plain)
        begin
            result_reg.accepted       <= 1'b0;
            result_reg.slot_index     <= 4'd0;
            result_reg.came_back      <= 1'b0;
            result_reg.received_count <= 32'd0;
            result_reg.lost_count     <= 32'd0;
            result_reg.timeout_mask   <= mask_reg;
        end
        else if (cmd.update)
        begin
            result_reg.accepted       <= 1'b1;
            result_reg.slot_index     <= 4'(sel_reg);
            result_reg.came_back      <= was_out_reg && item_reg.sensor_ok;
            result_reg.received_count <= recv_new;
            result_reg.lost_count     <= lost_new;
            result_reg.timeout_mask   <= '0;
        end
    end

    assign status.is_tick = is_tick;
    assign status.found   = hit_found_reg || free_found_reg;
    assign done           = done_reg;
    assign result         = result_reg;

endmodule

FILE: src/remote_sensor_liveness_table.sv
// remote_sensor_liveness_table: top level of the sensor slot table
// depends on rslt_pkg, rslt_ctrl and rslt_dpath
// a tick or a rejected packet gives its word after the scan, drain and pick states,
// a stored packet after the load and update states too; the next word is taken in the
// cycle its result is shown, no new word is taken while busy; the scan visits one slot
// a cycle through the read port of the slot record RAM; the receiver cannot stall
// reset: asynchronous, clears the slot flags and sequencer and reloads the timeouts;
// the record RAM is not cleared, its entries are ignored until the slot is first used
`timescale 1ns / 1ps

module remote_sensor_liveness_table #(
    parameter int SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rslt_pkg::item_t   item,
    output logic              done,
    output rslt_pkg::result_t result,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [23:0]       cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    rslt_pkg::ctrl_cmd_t    cmd;
    rslt_pkg::ctrl_status_t status;
    logic [IDX_W-1:0]       scan_addr;

    rslt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .status    (status),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    rslt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .scan_addr (scan_addr),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .done      (done),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a word was taken");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a word in work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_came_back_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.came_back) |-> (result.accepted && (result.timeout_mask == 16'd0)))
        else $error("came back flagged on a word that was not stored");
`endif

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for remote_sensor_liveness_table
// drives a directed table then random packet and tick words, checks every result word
// against a typed row's word or a slot table tracker; depends on rslt_pkg, rtl under src
`timescale 1ns / 1ps

module testbench;
    import rslt_pkg::*;

    localparam int SLOTS       = 16;
    localparam int DIR_ROWS    = 25;
    localparam int PHASE_WORDS = 275;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit          used;
        bit          healthy;
        bit          timed_out;
        logic [47:0] address;
        logic [7:0]  sensor_number;
        logic [2:0]  sensor_class;
        logic [31:0] last_arrival;
        logic [31:0] last_sequence;
        logic [31:0] received;
        logic [31:0] lost;
    } slot_state_t;

    typedef struct packed {
        item_t   word;
        logic    typed;
        result_t outcome;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    slot_state_t sensor_slots [SLOTS];
    logic [23:0] timeout_fast;
    logic [23:0] timeout_utility;
    logic [23:0] timeout_temp;
    logic [23:0] timeout_battery;
    logic [23:0] timeout_other;

    result_t     expected_words [$];
    stim_row_t   stim_rows [DIR_ROWS];
    int          mismatches;
    int          idle_pct;
    int          cycle_count;
    logic [31:0] now_clock;

    remote_sensor_liveness_table #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [23:0] class_limit(input logic [2:0] cls);
        case (cls)
            CLASS_FAST:    return timeout_fast;
            CLASS_UTILITY: return timeout_utility;
            CLASS_TEMP:    return timeout_temp;
            CLASS_BATTERY: return timeout_battery;
            default:       return timeout_other;
        endcase
    endfunction

    // advances the tracked slot table by one word and returns its result word
    function automatic result_t track_sensor_word(input item_t w);
        result_t     r;
        slot_state_t s;
        int          hit;
        int          free_slot;
        logic [32:0] gap;
        logic [32:0] sum;
        logic        was_out;
        r = '0;
        hit = -1;
        free_slot = -1;
        if (w.mode == MODE_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                s = sensor_slots[i];
                if (s.used && !s.timed_out && s.healthy && s.last_arrival != 32'd0
                    && w.now_ms >= s.last_arrival
                    && (w.now_ms - s.last_arrival) > {8'd0, class_limit(s.sensor_class)})
                begin
                    sensor_slots[i].healthy = 1'b0;
                    sensor_slots[i].timed_out = 1'b1;
                    if (i < 16)
                        r.timeout_mask[i] = 1'b1;
                end
            end
            return r;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sensor_slots[i].used && sensor_slots[i].address == w.sender_address
                && sensor_slots[i].sensor_number == w.sensor_id)
            begin
                hit = i;
                break;
            end
            if (!sensor_slots[i].used && free_slot < 0)
                free_slot = i;
        end
        if (hit < 0)
            hit = free_slot;
        if (hit < 0)
            return r;
        s = sensor_slots[hit];
        was_out = s.timed_out;
        s.used = 1'b1;
        s.address = w.sender_address;
        s.sensor_number = w.sensor_id;
        s.sensor_class = w.sensor_class;
        s.healthy = w.sensor_ok;
        if (w.sensor_ok)
            s.timed_out = 1'b0;
        s.last_arrival = w.now_ms;
        if (s.received != 32'd0
            && {1'b0, w.sequence_number} > {1'b0, s.last_sequence} + 33'd1)
        begin
            gap = {1'b0, w.sequence_number} - {1'b0, s.last_sequence} - 33'd1;
            sum = {1'b0, s.lost} + gap;
            s.lost = sum[32] ? COUNT_MAX : sum[31:0];
        end
        s.last_sequence = w.sequence_number;
        if (s.received != COUNT_MAX)
            s.received = s.received + 32'd1;
        sensor_slots[hit] = s;
        r.accepted = 1'b1;
        r.slot_index = hit[3:0];
        r.came_back = was_out && w.sensor_ok;
        r.received_count = s.received;
        r.lost_count = s.lost;
        return r;
    endfunction

    function automatic item_t packet_word(input logic [47:0] addr, input logic [7:0] sid,
                                          input logic [2:0] cls, input logic [31:0] seq,
                                          input logic ok, input logic [31:0] now);
        item_t w;
        w.mode = MODE_PACKET;
        w.sender_address = addr;
        w.sensor_id = sid;
        w.sensor_class = cls;
        w.sequence_number = seq;
        w.sensor_ok = ok;
        w.now_ms = now;
        return w;
    endfunction

    function automatic item_t tick_word(input logic [31:0] now);
        item_t w;
        w = '0;
        w.mode = MODE_TICK;
        w.now_ms = now;
        return w;
    endfunction

    function automatic result_t stored_result(input logic [3:0] slot, input logic back,
                                              input logic [31:0] rx, input logic [31:0] lost);
        result_t r;
        r = '0;
        r.accepted = 1'b1;
        r.slot_index = slot;
        r.came_back = back;
        r.received_count = rx;
        r.lost_count = lost;
        return r;
    endfunction

    function automatic result_t tick_result(input logic [15:0] mask);
        result_t r;
        r = '0;
        r.timeout_mask = mask;
        return r;
    endfunction

    function automatic stim_row_t make_row(input item_t w, input logic typed,
                                           input result_t outcome);
        stim_row_t row;
        row.word = w;
        row.typed = typed;
        row.outcome = outcome;
        return row;
    endfunction

    function automatic item_t random_word();
        item_t       w;
        int          pick;
        int          roll;
        logic [31:0] r32;
        logic [63:0] r64;
        logic [31:0] last;
        now_clock = now_clock + $urandom_range(0, 3000);
        pick = $urandom_range(0, SLOTS - 1);
        r32 = $urandom;
        r64 = {$urandom, $urandom};
        w.sender_address = r64[47:0];
        w.sensor_id = r32[7:0];
        w.sensor_class = r32[10:8];
        w.sequence_number = $urandom;
        w.sensor_ok = r32[11];
        w.mode = ($urandom_range(0, 99) < 30) ? MODE_TICK : MODE_PACKET;
        last = w.sequence_number;
        if (w.mode == MODE_PACKET && sensor_slots[pick].used && $urandom_range(0, 99) < 85)
        begin
            w.sender_address = sensor_slots[pick].address;
            w.sensor_id = sensor_slots[pick].sensor_number;
            last = sensor_slots[pick].last_sequence;
            if ($urandom_range(0, 99) < 70)
                w.sensor_class = sensor_slots[pick].sensor_class;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
            w.sequence_number = last + 32'd1;
        else if (roll < 75)
            w.sequence_number = last + $urandom_range(2, 20);
        else if (roll < 85)
            w.sequence_number = last - $urandom_range(0, 3);
        else if (roll >= 95)
            w.sequence_number = COUNT_MAX;
        w.sensor_ok = ($urandom_range(0, 99) < 85);
        roll = $urandom_range(0, 99);
        if (roll < 90)
            w.now_ms = now_clock;
        else if (roll < 95)
            w.now_ms = 32'd0;
        else
            w.now_ms = now_clock - $urandom_range(1, 5000);
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(result.accepted));
                check_field("slot_index", 32'(want.slot_index), 32'(result.slot_index));
                check_field("came_back", 32'(want.came_back), 32'(result.came_back));
                check_field("received_count", want.received_count, result.received_count);
                check_field("lost_count", want.lost_count, result.lost_count);
                check_field("timeout_mask", 32'(want.timeout_mask),
                            32'(result.timeout_mask));
            end
        end
    end

    task automatic send_word(input item_t w, input logic typed, input result_t outcome);
        result_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= w;
        do @(posedge clk); while (busy);
        predicted = track_sensor_word(w);
        expected_words.push_back(typed ? outcome : predicted);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [23:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        case (index)
            REG_TIMEOUT_FAST:    timeout_fast = value;
            REG_TIMEOUT_UTILITY: timeout_utility = value;
            REG_TIMEOUT_TEMP:    timeout_temp = value;
            REG_TIMEOUT_BATTERY: timeout_battery = value;
            default:             timeout_other = value;
        endcase
    endtask

    task automatic set_timeouts(input logic [23:0] fast, input logic [23:0] utility,
                                input logic [23:0] temp, input logic [23:0] battery,
                                input logic [23:0] other);
        write_reg(REG_TIMEOUT_FAST, fast);
        write_reg(REG_TIMEOUT_UTILITY, utility);
        write_reg(REG_TIMEOUT_TEMP, temp);
        write_reg(REG_TIMEOUT_BATTERY, battery);
        write_reg(REG_TIMEOUT_OTHER, other);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(input int pct);
        idle_pct = pct;
        for (int k = 0; k < PHASE_WORDS; k++)
        begin
            if (k == 120)
                wait_drained();
            send_word(random_word(), 1'b0, '0);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = REG_TIMEOUT_FAST;
        cfg_data = '0;
        idle_pct = 6;
        now_clock = 32'd2000;
        timeout_fast = TIMEOUT_FAST_RST;
        timeout_utility = TIMEOUT_UTILITY_RST;
        timeout_temp = TIMEOUT_TEMP_RST;
        timeout_battery = TIMEOUT_BATTERY_RST;
        timeout_other = TIMEOUT_OTHER_RST;
        for (int i = 0; i < SLOTS; i++)
            sensor_slots[i] = '{default: '0};

        // empty table, key extremes, sequence wrap, age at limit, come back, time zero
        stim_rows[0] = make_row(tick_word(32'd5000), 1'b1, '0);
        stim_rows[1] = make_row(packet_word(48'd0, 8'd0, CLASS_FAST, 32'd0, 1'b1, 32'd100),
                                1'b1, stored_result(4'd0, 1'b0, 32'd1, 32'd0));
        stim_rows[2] = make_row(packet_word(48'hFFFF_FFFF_FFFF, 8'hFF, 3'd7, COUNT_MAX, 1'b1,
                                            COUNT_MAX),
                                1'b1, stored_result(4'd1, 1'b0, 32'd1, 32'd0));
        stim_rows[3] = make_row(packet_word(48'hFFFF_FFFF_FFFF, 8'hFF, 3'd7, 32'd0, 1'b1,
                                            COUNT_MAX),
                                1'b1, stored_result(4'd1, 1'b0, 32'd2, 32'd0));
        stim_rows[4] = make_row(packet_word(48'd0, 8'd0, CLASS_FAST, 32'd5, 1'b1, 32'd100),
                                1'b1, stored_result(4'd0, 1'b0, 32'd2, 32'd4));
        stim_rows[5] = make_row(tick_word(32'd1100), 1'b1, '0);
        stim_rows[6] = make_row(tick_word(32'd1101), 1'b1, tick_result(16'h0001));
        stim_rows[7] = make_row(packet_word(48'd0, 8'd0, CLASS_FAST, 32'd6, 1'b0, 32'd1200),
                                1'b1, stored_result(4'd0, 1'b0, 32'd3, 32'd4));
        stim_rows[8] = make_row(packet_word(48'd0, 8'd0, CLASS_FAST, 32'd7, 1'b1, 32'd1300),
                                1'b1, stored_result(4'd0, 1'b1, 32'd4, 32'd4));
        stim_rows[9] = make_row(packet_word(48'h1234_5678_9ABC, 8'd1, CLASS_TEMP, 32'd100,
                                            1'b1, 32'd0),
                                1'b1, stored_result(4'd2, 1'b0, 32'd1, 32'd0));
        stim_rows[10] = make_row(tick_word(32'hFFFF_FFFE), 1'b1, tick_result(16'h0001));
        for (int k = 0; k < 13; k++)
            stim_rows[11 + k] = make_row(packet_word(48'h5A5A_0000_0000 | 48'(k),
                                                     8'h80 + 8'(k), 3'(k % 8),
                                                     32'(k * 3), (k % 4) != 3,
                                                     32'd1400 + 32'(k * 10)),
                                         1'b0, '0);
        // table full
        stim_rows[24] = make_row(packet_word(48'hC0DE_0000_0001, 8'd1, CLASS_TEMP, 32'd1,
                                             1'b1, 32'd1600),
                                 1'b1, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIR_ROWS; n++)
            send_word(stim_rows[n].word, stim_rows[n].typed, stim_rows[n].outcome);
        wait_drained();

        set_timeouts(24'd0, 24'hFF_FFFF, 24'd2500, 24'd1, 24'd6000);
        run_random(6);
        set_timeouts(24'($urandom_range(500, 8000)), 24'($urandom_range(500, 8000)),
                     24'($urandom_range(500, 8000)), 24'($urandom_range(500, 8000)),
                     24'($urandom_range(500, 8000)));
        run_random(66);
        set_timeouts(24'hFF_FFFF, 24'd0, 24'hFF_FFFE, 24'd3000, 24'd1500);
        run_random(0);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
